[design/block_sparse_row_insert_core_defines.svh]
// assertion macros shared by the block sparse row insert core
// depends on nothing; users must have clk and arst_n in scope
`ifndef BLOCK_SPARSE_ROW_INSERT_CORE_DEFINES_SVH
`define BLOCK_SPARSE_ROW_INSERT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BSRI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BSRI_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSRI_ASSERT(lbl, prop, msg)
`define BSRI_ASSERT_NR(lbl, prop, msg)
`endif
`endif

[design/bsri_pkg.sv]
// shared types and constants of the block sparse row insert core
// used by the controller, the datapath and the double adder
package bsri_pkg;

	localparam logic REQ_ACC  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam int          DBL_QUIET_BIT   = 51;
	localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [10:0] DBL_EXP_MAX     = 11'h7FF;

	// result to register at the end of an item
	typedef enum logic [2:0] {
		RES_NONE,
		RES_ZERO,
		RES_READ,
		RES_FOUND,
		RES_FULL
	} res_op_t;

	typedef struct packed {
		logic    load;
		logic    clr_wr;
		logic    fill_rd;
		logic    fill_ld;
		logic    scan_rd;
		logic    pos_inc;
		logic    blk_rd_pos;
		logic    fadd_go;
		logic    blk_wr_add;
		logic    j_init;
		logic    shift_rd;
		logic    shift_wr;
		logic    insert;
		res_op_t res_op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic is_read;
		logic pos_lt_fill;
		logic col_lt;
		logic col_eq;
		logic fill_full;
		logic j_gt_pos;
		logic fadd_done;
	} status_t;

endpackage

[design/block_sparse_row_insert_core.sv]
// block sparse row store with element accumulate and read, top level
// an item reads the fill count, then scans the row's column ids until one is not below block_col
// a hit reads or accumulates the element; an accumulate miss shifts slots and inserts a block
// throughput: one item at a time, start is taken whenever busy is low
// the result is shown on read_value, found and row_full with the single-cycle done and held after it
// after reset busy stays high while the fill counts are cleared
module block_sparse_row_insert_core #(
	parameter int ROWS = 256,
	parameter int ROW_CAPACITY = 8,
	parameter int BLOCK_DIM = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  row,
	input  logic [7:0]  block_col,
	input  logic [1:0]  elem_row,
	input  logic [1:0]  elem_col,
	input  logic [63:0] value,
	output logic        done,
	output logic [63:0] read_value,
	output logic        found,
	output logic        row_full
);
	import bsri_pkg::*;

	cmd_t    cmd;
	status_t st;

	bsri_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	bsri_datapath #(
		.ROWS        (ROWS),
		.ROW_CAPACITY(ROW_CAPACITY),
		.BLOCK_DIM   (BLOCK_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_type  (req_type),
		.row       (row),
		.block_col (block_col),
		.elem_row  (elem_row),
		.elem_col  (elem_col),
		.value     (value),
		.read_value(read_value),
		.found     (found),
		.row_full  (row_full)
	);

endmodule

[design/bsri_fadd.sv]
// iterative ieee 754 double adder, round to nearest even
// depends on bsri_pkg; one normalising bit per cycle
module bsri_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] sum,
	output logic        done
);
	import bsri_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_ALIGN, F_NORM, F_ROUND} fstate_t;

	fstate_t     state_q;
	logic        done_q;
	logic [63:0] sum_q;
	logic        spec_q;
	logic [63:0] spec_val_q;
	logic        sign_q;
	logic        sub_q;
	logic [11:0] exp_q;
	logic [52:0] mb_q;
	logic [52:0] ms_q;
	logic [10:0] d_q;
	logic [56:0] man_q;

	// unpack and order operands
	logic        a_nan, b_nan, a_inf, b_inf, swap_w, spec_w;
	logic [63:0] spec_val_w, big_w, sml_w;
	logic [10:0] eb_w, es_w;

	always_comb begin
		a_nan = (a[62:52] == DBL_EXP_MAX) && (a[51:0] != '0);
		b_nan = (b[62:52] == DBL_EXP_MAX) && (b[51:0] != '0);
		a_inf = (a[62:52] == DBL_EXP_MAX) && (a[51:0] == '0);
		b_inf = (b[62:52] == DBL_EXP_MAX) && (b[51:0] == '0);
		spec_w = a_nan || b_nan || a_inf || b_inf;
		if (a_nan)
			spec_val_w = a | (64'd1 << DBL_QUIET_BIT);
		else if (b_nan)
			spec_val_w = b | (64'd1 << DBL_QUIET_BIT);
		else if (a_inf)
			spec_val_w = (b_inf && (a[63] != b[63])) ? DBL_DEFAULT_NAN : a;
		else
			spec_val_w = b;
		swap_w = b[62:0] > a[62:0];
		big_w = swap_w ? b : a;
		sml_w = swap_w ? a : b;
		eb_w = (big_w[62:52] == '0) ? 11'd1 : big_w[62:52];
		es_w = (sml_w[62:52] == '0) ? 11'd1 : sml_w[62:52];
	end

	// alignment with sticky and the add or subtract
	logic [55:0] ext_s, sh_s, mask_s, al_s;
	logic        stk_s;

	always_comb begin
		ext_s = {ms_q, 3'b000};
		sh_s = ext_s >> d_q[5:0];
		mask_s = (56'd1 << d_q[5:0]) - 56'd1;
		stk_s = |(ext_s & mask_s);
		if (d_q >= 11'd56)
			al_s = {55'd0, |ms_q};
		else
			al_s = {sh_s[55:1], sh_s[0] | stk_s};
	end

	// rounding
	logic [52:0] rm;
	logic        up;
	logic [53:0] m54;
	logic [52:0] mfin;
	logic [11:0] efin;
	logic        sfin;
	logic [63:0] rres;

	always_comb begin
		rm = man_q[55:3];
		up = man_q[2] & (man_q[1] | man_q[0] | rm[0]);
		m54 = {1'b0, rm} + {53'd0, up};
		if (m54[53]) begin
			mfin = m54[53:1];
			efin = exp_q + 12'd1;
		end else begin
			mfin = m54[52:0];
			efin = exp_q;
		end
		sfin = (man_q == '0 && sub_q) ? 1'b0 : sign_q;
		if (efin >= 12'd2047)
			rres = {sfin, DBL_EXP_MAX, 52'd0};
		else
			rres = {sfin, (mfin[52] ? efin[10:0] : 11'd0), mfin[51:0]};
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (go)
						state_q <= F_ALIGN;
				end
				F_ALIGN: begin
					if (spec_q) begin
						done_q <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (!man_q[56] && (man_q[55] || exp_q <= 12'd1 || man_q == '0))
						state_q <= F_ROUND;
				end
				F_ROUND: begin
					done_q <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// operand and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (go) begin
					spec_q <= spec_w;
					spec_val_q <= spec_val_w;
					sign_q <= big_w[63];
					sub_q <= a[63] ^ b[63];
					exp_q <= {1'b0, eb_w};
					mb_q <= {big_w[62:52] != '0, big_w[51:0]};
					ms_q <= {sml_w[62:52] != '0, sml_w[51:0]};
					d_q <= eb_w - es_w;
				end
			end
			F_ALIGN: begin
				if (spec_q)
					sum_q <= spec_val_q;
				else if (sub_q)
					man_q <= {1'b0, mb_q, 3'b000} - {1'b0, al_s};
				else
					man_q <= {1'b0, mb_q, 3'b000} + {1'b0, al_s};
			end
			F_NORM: begin
				if (man_q[56]) begin
					man_q <= {1'b0, man_q[56:2], man_q[1] | man_q[0]};
					exp_q <= exp_q + 12'd1;
				end else if (!man_q[55] && exp_q > 12'd1 && man_q != '0) begin
					man_q <= {man_q[55:0], 1'b0};
					exp_q <= exp_q - 12'd1;
				end
			end
			F_ROUND: sum_q <= rres;
			default: ;
		endcase
	end

	assign sum = sum_q;
	assign done = done_q;

endmodule

[design/bsri_datapath.sv]
// datapath: fill counts, column ids, block store, request and result registers
// depends on bsri_pkg and bsri_fadd
module bsri_datapath #(
	parameter int ROWS = 256,
	parameter int ROW_CAPACITY = 8,
	parameter int BLOCK_DIM = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bsri_pkg::cmd_t   cmd,
	output bsri_pkg::status_t st,
	input  logic             req_type,
	input  logic [7:0]       row,
	input  logic [7:0]       block_col,
	input  logic [1:0]       elem_row,
	input  logic [1:0]       elem_col,
	input  logic [63:0]      value,
	output logic [63:0]      read_value,
	output logic             found,
	output logic             row_full
);
	import bsri_pkg::*;

	localparam int BLK_ELEMS = BLOCK_DIM * BLOCK_DIM;
	localparam int SLOTS = ROWS * ROW_CAPACITY;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW = $clog2(ROW_CAPACITY + 1);
	localparam int OW = (BLK_ELEMS > 1) ? $clog2(BLK_ELEMS) : 1;
	localparam int BW = BLK_ELEMS * 64;

	// latched item
	logic          type_q;
	logic [7:0]    row_q;
	logic [7:0]    col_q;
	logic [OW-1:0] off_q;
	logic [63:0]   val_q;
	logic          bad_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			row_q <= row;
			col_q <= block_col;
			off_q <= OW'(32'(elem_col) * 32'(BLOCK_DIM) + 32'(elem_row));
			val_q <= value;
			bad_q <= (32'(row) >= 32'(ROWS)) || (32'(elem_row) >= 32'(BLOCK_DIM))
				|| (32'(elem_col) >= 32'(BLOCK_DIM));
		end
	end

	// slot counters
	logic [FW-1:0] fill_q, pos_q, j_q;
	logic [FW-1:0] fill_rd_q;
	logic [RW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_wr)
			clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_ld) begin
			fill_q <= (fill_rd_q > FW'(ROW_CAPACITY)) ? FW'(ROW_CAPACITY) : fill_rd_q;
			pos_q <= '0;
		end
		if (cmd.pos_inc)
			pos_q <= pos_q + 1'b1;
		if (cmd.j_init)
			j_q <= fill_q;
		else if (cmd.shift_wr)
			j_q <= j_q - 1'b1;
	end

	// addresses
	logic [31:0]   base_w;
	logic [RW-1:0] row_idx;
	logic [SW-1:0] addr_pos, addr_j, addr_jm1, rd_addr, wr_addr;

	assign base_w = 32'(row_q) * 32'(ROW_CAPACITY);
	assign row_idx = RW'(row_q);
	assign addr_pos = SW'(base_w + 32'(pos_q));
	assign addr_j = SW'(base_w + 32'(j_q));
	assign addr_jm1 = SW'(base_w + 32'(j_q) - 32'd1);
	assign rd_addr = cmd.shift_rd ? addr_jm1 : addr_pos;
	assign wr_addr = cmd.shift_wr ? addr_j : addr_pos;

	// fill count store
	logic [FW-1:0] fill_mem [ROWS];

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			fill_mem[clr_q] <= '0;
		else if (cmd.insert)
			fill_mem[row_idx] <= fill_q + 1'b1;
		if (cmd.fill_rd)
			fill_rd_q <= fill_mem[row_idx];
	end

	// column id store
	logic [7:0] col_mem [SLOTS];
	logic [7:0] col_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_wr)
			col_mem[wr_addr] <= col_rd_q;
		else if (cmd.insert)
			col_mem[wr_addr] <= col_q;
		if (cmd.scan_rd || cmd.shift_rd)
			col_rd_q <= col_mem[rd_addr];
	end

	// element select, fresh block and updated block
	logic [BW-1:0] blk_rd_q, ins_blk, add_blk;
	logic [63:0]   elem, fsum;
	logic          fdone;

	always_comb begin
		elem = '0;
		for (int e = 0; e < BLK_ELEMS; e++) begin
			if (OW'(e) == off_q)
				elem = blk_rd_q[e*64 +: 64];
			ins_blk[e*64 +: 64] = (OW'(e) == off_q) ? val_q : 64'd0;
			add_blk[e*64 +: 64] = (OW'(e) == off_q) ? fsum : blk_rd_q[e*64 +: 64];
		end
	end

	// block store, one whole block per slot
	logic [BW-1:0] blk_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (cmd.shift_wr)
			blk_mem[wr_addr] <= blk_rd_q;
		else if (cmd.insert)
			blk_mem[wr_addr] <= ins_blk;
		else if (cmd.blk_wr_add)
			blk_mem[wr_addr] <= add_blk;
		if (cmd.blk_rd_pos || cmd.shift_rd)
			blk_rd_q <= blk_mem[rd_addr];
	end

	bsri_fadd u_fadd (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.fadd_go),
		.a     (elem),
		.b     (val_q),
		.sum   (fsum),
		.done  (fdone)
	);

	// result registers
	always_ff @(posedge clk) begin
		case (cmd.res_op)
			RES_ZERO: begin
				read_value <= '0;
				found <= 1'b0;
				row_full <= 1'b0;
			end
			RES_READ: begin
				read_value <= elem;
				found <= 1'b1;
				row_full <= 1'b0;
			end
			RES_FOUND: begin
				read_value <= '0;
				found <= 1'b1;
				row_full <= 1'b0;
			end
			RES_FULL: begin
				read_value <= '0;
				found <= 1'b0;
				row_full <= 1'b1;
			end
			default: ;
		endcase
	end

	// status
	always_comb begin
		st.clr_last = (clr_q == RW'(ROWS - 1));
		st.bad = bad_q;
		st.is_read = (type_q == REQ_READ);
		st.pos_lt_fill = pos_q < fill_q;
		st.col_lt = col_rd_q < col_q;
		st.col_eq = col_rd_q == col_q;
		st.fill_full = fill_q >= FW'(ROW_CAPACITY);
		st.j_gt_pos = j_q > pos_q;
		st.fadd_done = fdone;
	end

endmodule

[design/bsri_ctrl.sv]
// controller state machine: clearing pass, row scan, shift, insert, add
// depends on bsri_pkg and the assertion macro header
`include "block_sparse_row_insert_core_defines.svh"
module bsri_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bsri_pkg::status_t st,
	output bsri_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	import bsri_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FILL_RD, S_FILL_LD, S_SCAN_RD, S_SCAN_CK, S_MISS,
		S_HIT_RD, S_HIT_USE, S_ADD_WAIT, S_SHIFT_CHK, S_SHIFT_WR, S_INSERT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, done_q;

	// commands and next state
	always_comb begin
		cmd = '0;
		cmd.res_op = RES_NONE;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_FILL_RD;
				end
			end
			S_FILL_RD: begin
				if (st.bad) begin
					cmd.res_op = RES_ZERO;
					state_d = S_IDLE;
				end else begin
					cmd.fill_rd = 1'b1;
					state_d = S_FILL_LD;
				end
			end
			S_FILL_LD: begin
				cmd.fill_ld = 1'b1;
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (st.pos_lt_fill) begin
					cmd.scan_rd = 1'b1;
					state_d = S_SCAN_CK;
				end else begin
					state_d = S_MISS;
				end
			end
			S_SCAN_CK: begin
				if (st.col_lt) begin
					cmd.pos_inc = 1'b1;
					state_d = S_SCAN_RD;
				end else if (st.col_eq) begin
					state_d = S_HIT_RD;
				end else begin
					state_d = S_MISS;
				end
			end
			S_HIT_RD: begin
				cmd.blk_rd_pos = 1'b1;
				state_d = S_HIT_USE;
			end
			S_HIT_USE: begin
				if (st.is_read) begin
					cmd.res_op = RES_READ;
					state_d = S_IDLE;
				end else begin
					cmd.fadd_go = 1'b1;
					state_d = S_ADD_WAIT;
				end
			end
			S_ADD_WAIT: begin
				if (st.fadd_done) begin
					cmd.blk_wr_add = 1'b1;
					cmd.res_op = RES_FOUND;
					state_d = S_IDLE;
				end
			end
			S_MISS: begin
				if (st.is_read) begin
					cmd.res_op = RES_ZERO;
					state_d = S_IDLE;
				end else if (st.fill_full) begin
					cmd.res_op = RES_FULL;
					state_d = S_IDLE;
				end else begin
					cmd.j_init = 1'b1;
					state_d = S_SHIFT_CHK;
				end
			end
			S_SHIFT_CHK: begin
				if (st.j_gt_pos) begin
					cmd.shift_rd = 1'b1;
					state_d = S_SHIFT_WR;
				end else begin
					state_d = S_INSERT;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d = S_SHIFT_CHK;
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				cmd.res_op = RES_ZERO;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q <= (state_d != S_IDLE);
			done_q <= (cmd.res_op != RES_NONE);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	`BSRI_ASSERT_NR(a_done_not_busy, done_q |-> !busy_q, "result strobe while busy")
	`BSRI_ASSERT(a_accept_busy, (start && !busy_q) |=> busy_q, "item taken but not busy")
	`BSRI_ASSERT(a_done_single, done_q |=> !done_q, "result strobe longer than a cycle")

endmodule
